// ----- rtl/iecr_pkg.sv -----
// ----------------------------------------------------------------------------
// iecr_pkg
// Shared types, codes and helpers of the ICMP echo reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

package iecr_pkg;

    // duplicate bitmap size and packet limit
    localparam int          DUP_BITS   = 1024;
    localparam int          DUP_AW     = $clog2(DUP_BITS);
    localparam logic [15:0] MAX_PACKET = 16'hFFFF;

    // input action codes
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_SEND  = 2'd1;
    localparam logic [1:0] ACT_WDRAW = 2'd2;

    // event operation codes
    localparam logic [1:0] OP_PKT   = 2'd0;
    localparam logic [1:0] OP_SEND  = 2'd1;
    localparam logic [1:0] OP_WDRAW = 2'd2;

    // packet classes found by the parser
    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_REPLY  = 2'd1;
    localparam logic [1:0] CLS_ERROR  = 2'd2;
    localparam logic [1:0] CLS_QUENCH = 2'd3;

    // verdict codes
    localparam logic [2:0] V_IGNORED   = 3'd0;
    localparam logic [2:0] V_NEW       = 3'd1;
    localparam logic [2:0] V_BADSUM    = 3'd2;
    localparam logic [2:0] V_DUPLICATE = 3'd3;
    localparam logic [2:0] V_ERROR     = 3'd4;
    localparam logic [2:0] V_QUENCH    = 3'd5;
    localparam logic [2:0] V_SENT      = 3'd6;
    localparam logic [2:0] V_WITHDRAWN = 3'd7;

    // event passed from parser to tally side
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  cls;
        logic [15:0] seq;
        logic        shrt;
        logic        failed;
    } iecr_ev_t;

    // ones'-complement add of one word with end-around carry
    function automatic logic [16:0] csum_add(input logic [16:0] s, input logic [15:0] w);
        logic [17:0] t;
        t = {1'b0, s} + {2'b00, w};
        return {1'b0, t[15:0]} + {15'd0, t[17:16]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/iecr_fifo.sv -----
// ----------------------------------------------------------------------------
// iecr_fifo
// Two-entry event queue between parser and tally side.
// ----------------------------------------------------------------------------
`default_nettype none

module iecr_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  iecr_pkg::iecr_ev_t     push_ev,
    output logic                   can_push,
    output logic                   head_valid,
    output iecr_pkg::iecr_ev_t     head_ev,
    input  wire logic              pop
);
    import iecr_pkg::*;

    iecr_ev_t    slot_reg [2];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign can_push   = (cnt_reg != 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_ev    = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_ev;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/iecr_front.sv -----
// ----------------------------------------------------------------------------
// iecr_front
// Byte-wise IPv4/ICMP parser; classifies each packet on its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module iecr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [1:0]        action,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic [15:0]       ident_value,
    input  wire logic [15:0]       payload_len,
    output logic                   ev_push,
    output iecr_pkg::iecr_ev_t     ev
);
    import iecr_pkg::*;

    logic [15:0] pos_reg,  pos_next;
    logic [3:0]  ohl_reg,  ohl_next;
    logic [16:0] sum_reg,  sum_next;
    logic [7:0]  phb_reg,  phb_next;
    logic [31:0] odst_reg, odst_next;
    logic [7:0]  ityp_reg, ityp_next;
    logic [15:0] eid_reg,  eid_next;
    logic [15:0] eseq_reg, eseq_next;
    logic [3:0]  ihl_reg,  ihl_next;
    logic [31:0] isrc_reg, isrc_next;
    logic [23:0] itid_reg, itid_next;

    logic        take;
    logic [3:0]  ohl_eff;
    logic [5:0]  hlen;
    logic        icmp_on;
    logic [15:0] k;
    logic [6:0]  ic;
    logic [16:0] len;
    logic [16:0] ilen;
    logic [16:0] sum_fin;
    logic        hdr_ok;
    logic        is_byte;

    assign is_byte = (action == ACT_BYTE);
    assign ev_push = in_fire && ((action == ACT_SEND) || (action == ACT_WDRAW) ||
                                 (is_byte && last_byte));

    // field capture for one byte
    always_comb
    begin
        take      = (pos_reg != MAX_PACKET);
        ohl_eff   = (pos_reg == 16'd0) ? data_byte[3:0] : ohl_reg;
        hlen      = {ohl_eff, 2'b00};
        icmp_on   = take && (pos_reg >= {10'd0, hlen});
        k         = pos_reg - {10'd0, hlen};

        ohl_next  = ohl_reg;
        sum_next  = sum_reg;
        phb_next  = phb_reg;
        odst_next = odst_reg;
        ityp_next = ityp_reg;
        eid_next  = eid_reg;
        eseq_next = eseq_reg;
        ihl_next  = ihl_reg;
        isrc_next = isrc_reg;
        itid_next = itid_reg;

        if (take && (pos_reg == 16'd0))
        begin
            ohl_next = data_byte[3:0];
        end
        if (take && (pos_reg >= 16'd16) && (pos_reg <= 16'd19))
        begin
            odst_next = {odst_reg[23:0], data_byte};
        end
        if (icmp_on)
        begin
            if (!k[0])
            begin
                phb_next = data_byte;
            end
            else
            begin
                sum_next = csum_add(sum_reg, {phb_reg, data_byte});
            end
            if (k == 16'd0)
            begin
                ityp_next = data_byte;
            end
            if ((k == 16'd4) || (k == 16'd5))
            begin
                eid_next = {eid_reg[7:0], data_byte};
            end
            if ((k == 16'd6) || (k == 16'd7))
            begin
                eseq_next = {eseq_reg[7:0], data_byte};
            end
            if (k == 16'd8)
            begin
                ihl_next = data_byte[3:0];
            end
            if ((k >= 16'd20) && (k <= 16'd23))
            begin
                isrc_next = {isrc_reg[23:0], data_byte};
            end
        end
        ic = 7'd8 + {1'b0, ihl_next, 2'b00};
        if (icmp_on && ((k == {9'd0, ic}) || (k == {9'd0, ic + 7'd4}) ||
                        (k == {9'd0, ic + 7'd5})))
        begin
            itid_next = {itid_reg[15:0], data_byte};
        end
    end

    // packet classification on the final byte
    always_comb
    begin
        len     = {1'b0, pos_reg} + 17'd1;
        ilen    = len - {11'd0, ohl_next, 2'b00};
        hdr_ok  = take && (ohl_next >= 4'd5) &&
                  (len >= ({11'd0, ohl_next, 2'b00} + 17'd8));
        sum_fin = ilen[0] ? csum_add(sum_next, {phb_next, 8'h00}) : sum_next;

        ev        = '0;
        ev.seq    = eseq_next;
        ev.failed = (sum_fin != 17'h0FFFF);
        ev.shrt   = (ilen < ({1'b0, payload_len} + 17'd8));
        ev.cls    = CLS_NONE;
        unique case (action)
            ACT_SEND:  ev.op = OP_SEND;
            ACT_WDRAW: ev.op = OP_WDRAW;
            default:   ev.op = OP_PKT;
        endcase

        if (hdr_ok)
        begin
            if (ityp_next == 8'd0)
            begin
                if (eid_next == ident_value)
                begin
                    ev.cls = CLS_REPLY;
                end
            end
            else if ((ityp_next == 8'd3) || (ityp_next == 8'd4) ||
                     (ityp_next == 8'd11) || (ityp_next == 8'd12))
            begin
                if ((ilen >= 17'd36) &&
                    (ilen >= (17'd16 + {11'd0, ihl_next, 2'b00})) &&
                    (itid_next[23:16] == 8'd8) && (isrc_next == odst_next) &&
                    (itid_next[15:0] == ident_value))
                begin
                    ev.cls = (ityp_next == 8'd4) ? CLS_QUENCH : CLS_ERROR;
                end
            end
        end
    end

    // next byte position
    always_comb
    begin
        pos_next = pos_reg;
        if (last_byte)
        begin
            pos_next = 16'd0;
        end
        else if (take)
        begin
            pos_next = pos_reg + 16'd1;
        end
    end

    // parser state, cleared at packet end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            ohl_reg  <= '0;
            sum_reg  <= '0;
            phb_reg  <= '0;
            odst_reg <= '0;
            ityp_reg <= '0;
            eid_reg  <= '0;
            eseq_reg <= '0;
            ihl_reg  <= '0;
            isrc_reg <= '0;
            itid_reg <= '0;
        end
        else if (in_fire && is_byte)
        begin
            pos_reg <= pos_next;
            if (last_byte)
            begin
                ohl_reg  <= '0;
                sum_reg  <= '0;
                phb_reg  <= '0;
                odst_reg <= '0;
                ityp_reg <= '0;
                eid_reg  <= '0;
                eseq_reg <= '0;
                ihl_reg  <= '0;
                isrc_reg <= '0;
                itid_reg <= '0;
            end
            else
            begin
                ohl_reg  <= ohl_next;
                sum_reg  <= sum_next;
                phb_reg  <= phb_next;
                odst_reg <= odst_next;
                ityp_reg <= ityp_next;
                eid_reg  <= eid_next;
                eseq_reg <= eseq_next;
                ihl_reg  <= ihl_next;
                isrc_reg <= isrc_next;
                itid_reg <= itid_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/iecr_back.sv -----
// ----------------------------------------------------------------------------
// iecr_back
// Duplicate bitmap, tallies and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iecr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ev_valid,
    input  iecr_pkg::iecr_ev_t     ev,
    output logic                   ev_pop,
    output logic                   clearing,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [15:0]            sequence_res,
    output logic [2:0]             verdict,
    output logic                   reply_short,
    output logic [31:0]            received_count,
    output logic [31:0]            repeat_count,
    output logic [31:0]            bad_checksum_count,
    output logic [31:0]            error_count,
    output logic [31:0]            transmitted_count
);
    import iecr_pkg::*;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    logic              seen_mem [DUP_BITS];
    logic              clr_reg;
    logic [DUP_AW-1:0] clr_cnt_reg;
    logic              b_valid_reg;
    iecr_ev_t          b_ev_reg;
    logic              rd_reg;
    logic              fwd_hit_reg;
    logic              fwd_val_reg;
    logic              o_valid_reg;
    logic [15:0]       o_seq_reg, o_seq_next;
    logic [2:0]        o_verdict_reg, o_verdict_next;
    logic              o_shrt_reg, o_shrt_next;
    logic [31:0]       rcv_reg, rcv_next;
    logic [31:0]       rep_reg, rep_next;
    logic [31:0]       bad_reg, bad_next;
    logic [31:0]       err_reg, err_next;
    logic [31:0]       tx_reg, tx_next;

    logic              b_fire;
    logic              bit_seen;
    logic              upd_we;
    logic [DUP_AW-1:0] upd_wa;
    logic              upd_wd;
    logic              mem_we;
    logic [DUP_AW-1:0] mem_wa;
    logic              mem_wd;
    logic [DUP_AW-1:0] rd_addr;

    assign clearing = clr_reg;
    assign b_fire   = b_valid_reg && (!o_valid_reg || out_ready);
    assign ev_pop   = ev_valid && !clr_reg && (!b_valid_reg || b_fire);
    assign rd_addr  = ev.seq[DUP_AW-1:0];
    assign bit_seen = fwd_hit_reg ? fwd_val_reg : rd_reg;

    // verdict and tally update for the request in the work stage
    always_comb
    begin
        o_seq_next     = 16'd0;
        o_verdict_next = V_IGNORED;
        o_shrt_next    = 1'b0;
        rcv_next       = rcv_reg;
        rep_next       = rep_reg;
        bad_next       = bad_reg;
        err_next       = err_reg;
        tx_next        = tx_reg;
        upd_we         = 1'b0;
        upd_wa         = b_ev_reg.seq[DUP_AW-1:0];
        upd_wd         = 1'b1;
        unique case (b_ev_reg.op)
            OP_SEND:
            begin
                o_seq_next     = tx_reg[15:0];
                o_verdict_next = V_SENT;
                tx_next        = sat_inc(tx_reg);
                upd_we         = 1'b1;
                upd_wa         = tx_reg[DUP_AW-1:0];
                upd_wd         = 1'b0;
            end
            OP_WDRAW:
            begin
                if (tx_reg != 32'd0)
                begin
                    tx_next        = tx_reg - 32'd1;
                    o_seq_next     = tx_next[15:0];
                    o_verdict_next = V_WITHDRAWN;
                end
            end
            default:
            begin
                unique case (b_ev_reg.cls)
                    CLS_REPLY:
                    begin
                        o_seq_next  = b_ev_reg.seq;
                        o_shrt_next = b_ev_reg.shrt;
                        if (b_ev_reg.failed)
                        begin
                            o_verdict_next = V_BADSUM;
                            bad_next       = sat_inc(bad_reg);
                        end
                        else if (bit_seen)
                        begin
                            o_verdict_next = V_DUPLICATE;
                            rep_next       = sat_inc(rep_reg);
                        end
                        else
                        begin
                            o_verdict_next = V_NEW;
                            rcv_next       = sat_inc(rcv_reg);
                            upd_we         = 1'b1;
                        end
                    end
                    CLS_ERROR:
                    begin
                        o_verdict_next = V_ERROR;
                        err_next       = sat_inc(err_reg);
                    end
                    CLS_QUENCH: o_verdict_next = V_QUENCH;
                    default:    o_verdict_next = V_IGNORED;
                endcase
            end
        endcase
    end

    // bitmap write port: clearing sweep or update
    always_comb
    begin
        if (clr_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = 1'b0;
        end
        else
        begin
            mem_we = b_fire && upd_we;
            mem_wa = upd_wa;
            mem_wd = upd_wd;
        end
    end

    // bitmap memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seen_mem[mem_wa] <= mem_wd;
        end
        if (ev_pop)
        begin
            rd_reg <= seen_mem[rd_addr];
        end
    end

    // work stage payload and write-to-read forwarding
    always_ff @(posedge clk)
    begin
        if (ev_pop)
        begin
            b_ev_reg    <= ev;
            fwd_hit_reg <= mem_we && (mem_wa == rd_addr);
            fwd_val_reg <= mem_wd;
        end
        if (b_fire)
        begin
            o_seq_reg     <= o_seq_next;
            o_verdict_reg <= o_verdict_next;
            o_shrt_reg    <= o_shrt_next;
        end
    end

    // control, sweep and tallies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            rcv_reg     <= '0;
            rep_reg     <= '0;
            bad_reg     <= '0;
            err_reg     <= '0;
            tx_reg      <= '0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == DUP_AW'(DUP_BITS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (ev_pop)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire)
            begin
                o_valid_reg <= 1'b1;
                rcv_reg     <= rcv_next;
                rep_reg     <= rep_next;
                bad_reg     <= bad_next;
                err_reg     <= err_next;
                tx_reg      <= tx_next;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid          = o_valid_reg;
    assign sequence_res       = o_seq_reg;
    assign verdict            = o_verdict_reg;
    assign reply_short        = o_shrt_reg;
    assign received_count     = rcv_reg;
    assign repeat_count       = rep_reg;
    assign bad_checksum_count = bad_reg;
    assign error_count        = err_reg;
    assign transmitted_count  = tx_reg;

endmodule

`default_nettype wire

// ----- rtl/icmp_echo_reply_checker_unit.sv -----
// Path: a send, withdraw or final packet byte reaches its result through the queue,
//   the work stage and the result register.
// Throughput: one request per cycle while in_ready is high (queue not full, no
//   sweep); the parser and the bitmap port each handle one request a cycle.
// Reset: after rst_n is released the 1024-entry bitmap is swept clear,
//   one entry a cycle; in_ready stays low until the sweep is done.
// ----------------------------------------------------------------------------
// icmp_echo_reply_checker_unit
// Parses received packets, tracks echo sequence numbers and keeps tallies.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_echo_reply_checker_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      sequence_res,
    output logic [2:0]       verdict,
    output logic             reply_short,
    output logic [31:0]      received_count,
    output logic [31:0]      repeat_count,
    output logic [31:0]      bad_checksum_count,
    output logic [31:0]      error_count,
    output logic [31:0]      transmitted_count
);
    import iecr_pkg::*;

    localparam logic [0:0] REG_IDENT   = 1'd0;
    localparam logic [0:0] REG_PAYLOAD = 1'd1;

    logic [15:0] ident_reg;
    logic [15:0] plen_reg;
    logic        in_fire;
    logic        ev_push;
    iecr_ev_t    push_ev;
    logic        can_push;
    logic        head_valid;
    iecr_ev_t    head_ev;
    logic        ev_pop;
    logic        clearing;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg <= 16'd0;
            plen_reg  <= 16'd56;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IDENT:   ident_reg <= cfg_data;
                REG_PAYLOAD: plen_reg  <= cfg_data;
                default:     ident_reg <= ident_reg;
            endcase
        end
    end

    assign in_ready = can_push && !clearing;
    assign in_fire  = in_valid && in_ready;

    iecr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .action      (action),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .ident_value (ident_reg),
        .payload_len (plen_reg),
        .ev_push     (ev_push),
        .ev          (push_ev)
    );

    iecr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (ev_push),
        .push_ev    (push_ev),
        .can_push   (can_push),
        .head_valid (head_valid),
        .head_ev    (head_ev),
        .pop        (ev_pop)
    );

    iecr_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .ev_valid           (head_valid),
        .ev                 (head_ev),
        .ev_pop             (ev_pop),
        .clearing           (clearing),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .sequence_res       (sequence_res),
        .verdict            (verdict),
        .reply_short        (reply_short),
        .received_count     (received_count),
        .repeat_count       (repeat_count),
        .bad_checksum_count (bad_checksum_count),
        .error_count        (error_count),
        .transmitted_count  (transmitted_count)
    );

    // a sent result always leaves a nonzero transmit tally
    a_sent_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict == V_SENT)) |-> (transmitted_count != 32'd0))
        else $error("send result with zero transmit tally");

    // a withdraw reports the new transmit tally
    a_wdraw_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict == V_WITHDRAWN)) |->
        (sequence_res == transmitted_count[15:0]))
        else $error("withdraw sequence does not match tally");

    // a duplicate always leaves a nonzero repeat tally
    a_dup_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict == V_DUPLICATE)) |-> (repeat_count != 32'd0))
        else $error("duplicate result with zero repeat tally");

    // received tally only ever steps up by one
    a_rcv_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(received_count) |-> (received_count == $past(received_count) + 32'd1))
        else $error("received tally jumped");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives send, withdraw and packet-byte requests into the ICMP echo reply
// checker, predicts every verdict and tally, and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import iecr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] dat;
        logic       lst;
    } req_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [2:0]  vrd;
        logic        shrt;
        logic [31:0] rcv;
        logic [31:0] rpt;
        logic [31:0] bad;
        logic [31:0] err;
        logic [31:0] xmt;
    } verdict_t;

    localparam logic       REG_IDENT   = 1'b0;
    localparam logic       REG_PAYLOAD = 1'b1;
    localparam logic [1:0] ACT_NOP     = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] sequence_res;
    logic [2:0]  verdict;
    logic        reply_short;
    logic [31:0] received_count;
    logic [31:0] repeat_count;
    logic [31:0] bad_checksum_count;
    logic [31:0] error_count;
    logic [31:0] transmitted_count;

    icmp_echo_reply_checker_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .sequence_res(sequence_res), .verdict(verdict), .reply_short(reply_short),
        .received_count(received_count), .repeat_count(repeat_count),
        .bad_checksum_count(bad_checksum_count), .error_count(error_count),
        .transmitted_count(transmitted_count)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [15:0] ident_reg;
    logic [15:0] plen_reg;
    logic        seen_bits [DUP_BITS];
    logic [31:0] tally [5];
    int unsigned pos, ohl, csum, hi_byte, odst, ityp, eid, eseq, ihl, isrc, itid;

    req_t     pending_reqs[$];
    verdict_t expected_verdicts[$];
    int       errors;
    int       results_seen;
    int       packets_sent;
    int       items_queued;
    bit       idle_free;
    bit       drive_done;

    // counters stats
    int n_new, n_dup, n_bad, n_err, n_quench;

    task automatic bump(input int idx);
        if (tally[idx] != 32'hFFFF_FFFF)
            tally[idx] = tally[idx] + 1;
    endtask

    task automatic add_word(input int unsigned w);
        int unsigned s;
        s = csum + (w & 16'hFFFF);
        csum = (s & 16'hFFFF) + (s >> 16);
    endtask

    task automatic clear_parse();
        pos = 0; ohl = 0; csum = 0; hi_byte = 0; odst = 0; ityp = 0;
        eid = 0; eseq = 0; ihl = 0; isrc = 0; itid = 0;
    endtask

    task automatic absorb_byte(input int unsigned b);
        int unsigned k, ic;
        if (pos == 0)
            ohl = b & 4'hF;
        if (pos >= 16 && pos <= 19)
            odst = (odst << 8) | b;
        if (pos >= ohl * 4)
        begin
            k = pos - ohl * 4;
            if ((k & 1) == 0)
                hi_byte = b;
            else
                add_word((hi_byte << 8) | b);
            if (k == 0)
                ityp = b;
            if (k == 4 || k == 5)
                eid = ((eid << 8) | b) & 16'hFFFF;
            if (k == 6 || k == 7)
                eseq = ((eseq << 8) | b) & 16'hFFFF;
            if (k == 8)
                ihl = b & 4'hF;
            if (k >= 20 && k <= 23)
                isrc = (isrc << 8) | b;
            ic = 8 + ihl * 4;
            if (k == ic || k == ic + 4 || k == ic + 5)
                itid = ((itid << 8) | b) & 24'hFFFFFF;
        end
    endtask

    // classify a finished packet
    task automatic classify(inout verdict_t r);
        int unsigned len, ilen, bit_ix;
        if (pos >= 65535)
            return;
        len = pos + 1;
        if (ohl < 5 || len < ohl * 4 + 8)
            return;
        ilen = len - ohl * 4;
        if (ilen & 1)
            add_word(hi_byte << 8);
        if (ityp == 0)
        begin
            if (eid != ident_reg)
                return;
            r.seq = eseq[15:0];
            r.shrt = (ilen < plen_reg + 8);
            bit_ix = eseq % DUP_BITS;
            if (csum != 16'hFFFF)
            begin
                bump(2); r.vrd = V_BADSUM;
            end
            else if (seen_bits[bit_ix])
            begin
                bump(1); r.vrd = V_DUPLICATE;
            end
            else
            begin
                seen_bits[bit_ix] = 1'b1; bump(0); r.vrd = V_NEW;
            end
            return;
        end
        if (ityp == 3 || ityp == 4 || ityp == 11 || ityp == 12)
        begin
            if (ilen < 36 || ilen < 16 + ihl * 4)
                return;
            if ((itid >> 16) != 8 || isrc != odst || (itid & 16'hFFFF) != ident_reg)
                return;
            if (ityp == 4)
                r.vrd = V_QUENCH;
            else
            begin
                bump(3); r.vrd = V_ERROR;
            end
        end
    endtask

    task automatic predict_checker(input req_t q);
        verdict_t r;
        r = '0;
        if (q.act == ACT_BYTE)
        begin
            if (pos < 65535)
            begin
                absorb_byte(q.dat);
                if (!q.lst)
                    pos++;
            end
            if (!q.lst)
                return;
            classify(r);
            clear_parse();
        end
        else if (q.act == ACT_SEND)
        begin
            r.seq = tally[4][15:0];
            seen_bits[tally[4] % DUP_BITS] = 1'b0;
            bump(4);
            r.vrd = V_SENT;
        end
        else if (q.act == ACT_WDRAW)
        begin
            if (tally[4] != 0)
            begin
                tally[4] = tally[4] - 1;
                r.seq = tally[4][15:0];
                r.vrd = V_WITHDRAWN;
            end
        end
        else
            return;
        r.rcv = tally[0]; r.rpt = tally[1]; r.bad = tally[2];
        r.err = tally[3]; r.xmt = tally[4];
        expected_verdicts.push_back(r);
    endtask

    // packet builders
    task automatic queue_bytes(input byte unsigned pkt[$]);
        foreach (pkt[i])
            pending_reqs.push_back('{ACT_BYTE, pkt[i], i == pkt.size() - 1});
        items_queued += pkt.size();
        packets_sent++;
    endtask

    function automatic void fix_sum(ref byte unsigned pkt[$], input int hl);
        int unsigned s;
        s = 0;
        for (int i = hl; i < pkt.size(); i += 2)
        begin
            s += (pkt[i] << 8) | ((i + 1 < pkt.size()) ? pkt[i + 1] : 0);
            s = (s & 16'hFFFF) + (s >> 16);
        end
        s = ~s & 16'hFFFF;
        pkt[hl + 2] = s[15:8];
        pkt[hl + 3] = s[7:0];
    endfunction

    // ip header plus icmp echo reply or error report
    task automatic make_packet(input int typ, input int id, input int sq, input int plen,
                               input bit good_sum, input int ihl_words);
        byte unsigned pkt[$];
        int hl, ibase;
        hl = ihl_words * 4;
        for (int i = 0; i < hl; i++)
            pkt.push_back($urandom_range(0, 255));
        pkt[0] = {4'h4, ihl_words[3:0]};
        pkt.push_back(typ); pkt.push_back($urandom_range(0, 255));
        pkt.push_back(0); pkt.push_back(0);
        if (typ == 0)
        begin
            pkt.push_back(id[15:8]); pkt.push_back(id[7:0]);
            pkt.push_back(sq[15:8]); pkt.push_back(sq[7:0]);
            for (int i = 0; i < plen; i++)
                pkt.push_back($urandom_range(0, 255));
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                pkt.push_back($urandom_range(0, 255));
            ibase = pkt.size();
            for (int i = 0; i < 20; i++)
                pkt.push_back($urandom_range(0, 255));
            pkt[ibase] = 8'h45;
            for (int i = 0; i < 4; i++)
                pkt[ibase + 12 + i] = pkt[16 + i];
            pkt.push_back(8); pkt.push_back(0); pkt.push_back(0); pkt.push_back(0);
            pkt.push_back(id[15:8]); pkt.push_back(id[7:0]);
            pkt.push_back(sq[15:8]); pkt.push_back(sq[7:0]);
            for (int i = 0; i < plen; i++)
                pkt.push_back($urandom_range(0, 255));
        end
        if (good_sum)
            fix_sum(pkt, hl);
        queue_bytes(pkt);
    endtask

    task automatic push_act(input logic [1:0] a);
        pending_reqs.push_back('{a, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
        items_queued++;
    endtask

    task automatic run_phase();
        while (pending_reqs.size() != 0 || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_IDENT)
            ident_reg = val;
        else
            plen_reg = val;
    endtask

    task automatic random_phase(input int n_items);
        int start, r, sq;
        start = items_queued;
        while (items_queued - start < n_items)
        begin
            r = $urandom_range(0, 99);
            sq = (tally[4] == 0) ? 0 : ((tally[4] - 1 - $urandom_range(0, 5)) & 16'hFFFF);
            if (r < 25)
                push_act(ACT_SEND);
            else if (r < 30)
                push_act(ACT_WDRAW);
            else if (r < 32)
                push_act(ACT_NOP);
            else if (r < 70)
            begin
                make_packet(0, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                            : ident_reg, ($urandom_range(0, 9) == 0) ?
                            $urandom_range(0, 65535) : sq, $urandom_range(0, 24),
                            $urandom_range(0, 9) != 0, ($urandom_range(0, 4) == 0) ?
                            $urandom_range(5, 15) : 5);
            end
            else if (r < 85)
            begin
                make_packet(($urandom_range(0, 1)) ? 3 : (($urandom_range(0, 1)) ? 4 : 11),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                            : ident_reg, sq, $urandom_range(0, 4), 1'b1, 5);
            end
            else
            begin
                // noise packet with random bytes
                byte unsigned pkt[$];
                int ln;
                ln = $urandom_range(1, 50);
                for (int i = 0; i < ln; i++)
                    pkt.push_back($urandom_range(0, 255));
                if ($urandom_range(0, 1))
                    pkt[0] = {4'h4, 4'($urandom_range(0, 15))};
                queue_bytes(pkt);
            end
        end
        run_phase();
    endtask

    // stimulus
    initial
    begin
        cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
        errors = 0; results_seen = 0; packets_sent = 0; items_queued = 0;
        n_new = 0; n_dup = 0; n_bad = 0; n_err = 0; n_quench = 0;
        idle_free = 1'b0; drive_done = 1'b0;
        ident_reg = 16'd0; plen_reg = 16'd56;
        for (int i = 0; i < DUP_BITS; i++)
            seen_bits[i] = 1'b0;
        for (int i = 0; i < 5; i++)
            tally[i] = 0;
        clear_parse();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: withdraw with nothing sent, sends, all packet kinds
        push_act(ACT_WDRAW);
        push_act(ACT_NOP);
        push_act(ACT_SEND);
        push_act(ACT_SEND);
        make_packet(0, 0, 0, 56, 1'b1, 5);
        make_packet(0, 0, 0, 0, 1'b1, 5);
        make_packet(0, 0, 1, 10, 1'b0, 6);
        make_packet(0, 16'hFFFF, 1, 0, 1'b1, 5);
        make_packet(3, 0, 0, 0, 1'b1, 5);
        make_packet(4, 0, 0, 0, 1'b1, 5);
        make_packet(12, 0, 0, 0, 1'b1, 5);
        make_packet(8, 0, 0, 0, 1'b1, 5);
        pending_reqs.push_back('{ACT_BYTE, 8'hFF, 1'b0});
        pending_reqs.push_back('{ACT_BYTE, 8'h00, 1'b1});
        items_queued += 2;
        push_act(ACT_WDRAW);
        run_phase();

        write_reg(REG_IDENT, 16'hFFFF);
        write_reg(REG_PAYLOAD, 16'd0);
        random_phase(100);
        write_reg(REG_IDENT, 16'($urandom_range(0, 65535)));
        write_reg(REG_PAYLOAD, 16'd65507);
        idle_free = 1'b1;
        random_phase(80);
        idle_free = 1'b0;
        write_reg(REG_PAYLOAD, 16'($urandom_range(0, 20)));
        random_phase(150);

        drive_done = 1'b1;
        repeat (10) @(posedge clk);

        $display("covered %0d requests in %0d packets, %0d results: new %0d dup %0d badsum %0d err %0d quench %0d",
                 items_queued, packets_sent, results_seen, n_new, n_dup, n_bad, n_err,
                 n_quench);
        if (errors == 0)
            $display("** icmp_echo_reply_checker_unit: PASSED **");
        else
            $display("** icmp_echo_reply_checker_unit: FAILED **");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0; action <= '0; data_byte <= '0; last_byte <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_checker('{action, data_byte, last_byte});
            if (pending_reqs.size() != 0 && (idle_free || $urandom_range(0, 99) >= 29))
            begin
                req_t q;
                q = pending_reqs.pop_front();
                in_valid <= 1'b1; action <= q.act; data_byte <= q.dat; last_byte <= q.lst;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                verdict_t e;
                results_seen++;
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result, verdict %0d", verdict);
                    errors++;
                end
                else
                begin
                    e = expected_verdicts.pop_front();
                    case (e.vrd)
                        V_NEW: n_new++;
                        V_DUPLICATE: n_dup++;
                        V_BADSUM: n_bad++;
                        V_ERROR: n_err++;
                        V_QUENCH: n_quench++;
                        default: ;
                    endcase
                    if (sequence_res !== e.seq)
                    begin
                        $error("sequence_res exp %0d got %0d", e.seq, sequence_res); errors++;
                    end
                    if (verdict !== e.vrd)
                    begin
                        $error("verdict exp %0d got %0d", e.vrd, verdict); errors++;
                    end
                    if (reply_short !== e.shrt)
                    begin
                        $error("reply_short exp %0d got %0d", e.shrt, reply_short); errors++;
                    end
                    if (received_count !== e.rcv)
                    begin
                        $error("received_count exp %0d got %0d", e.rcv, received_count);
                        errors++;
                    end
                    if (repeat_count !== e.rpt)
                    begin
                        $error("repeat_count exp %0d got %0d", e.rpt, repeat_count); errors++;
                    end
                    if (bad_checksum_count !== e.bad)
                    begin
                        $error("bad_checksum_count exp %0d got %0d", e.bad,
                               bad_checksum_count);
                        errors++;
                    end
                    if (error_count !== e.err)
                    begin
                        $error("error_count exp %0d got %0d", e.err, error_count); errors++;
                    end
                    if (transmitted_count !== e.xmt)
                    begin
                        $error("transmitted_count exp %0d got %0d", e.xmt, transmitted_count);
                        errors++;
                    end
                end
            end
            out_ready <= idle_free || ($urandom_range(0, 99) >= 29);
        end
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("** icmp_echo_reply_checker_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/iecr_pkg.sv
rtl/iecr_fifo.sv
rtl/iecr_front.sv
rtl/iecr_back.sv
rtl/icmp_echo_reply_checker_unit.sv
tb/testbench.sv
